@@ sv/aesf_pkg.sv @@
`timescale 1ns / 1ps
// Package for the ECMA-48 escape sequence framer.
// Parse mode codes, character constants and default sizes; no dependencies.
package aesf_pkg;

    localparam int COUNT_BITS_DEF = 16;
    localparam int IN_DATA_W      = 8;
    localparam int OUT_DATA_W     = 40;
    localparam int FIELD_W        = 16;

    localparam logic [2:0] M_ASCII = 3'd0;
    localparam logic [2:0] M_ESC   = 3'd1;
    localparam logic [2:0] M_CSI1  = 3'd2;
    localparam logic [2:0] M_CSI2  = 3'd3;
    localparam logic [2:0] M_SS    = 3'd4;
    localparam logic [2:0] M_NF    = 3'd5;
    localparam logic [2:0] M_STR   = 3'd6;
    localparam logic [2:0] M_STR2  = 3'd7;

    localparam logic [7:0] CH_BEL   = 8'h07;
    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SS2   = 8'h4E;
    localparam logic [7:0] CH_SS3   = 8'h4F;
    localparam logic [7:0] CH_DCS   = 8'h50;
    localparam logic [7:0] CH_SOS   = 8'h58;
    localparam logic [7:0] CH_CSI   = 8'h5B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_OSC   = 8'h5D;
    localparam logic [7:0] CH_PM    = 8'h5E;
    localparam logic [7:0] CH_APC   = 8'h5F;
    localparam logic [7:0] CH_C1ST  = 8'h9C;
    localparam logic [7:0] CH_CONT  = 8'h80;
    localparam logic [7:0] CH_LEAD  = 8'hC0;
    localparam logic [7:0] CH_C2    = 8'hC2;

    // Result of handling a byte as the first of a sequence.
    typedef struct packed {
        logic       done;
        logic [2:0] mode;
    } first_res_t;

    function automatic first_res_t ascii_byte(input logic [7:0] c);
        first_res_t r;
        r.mode = M_ASCII;
        r.done = 1'b1;
        if (c < CH_CONT)
        begin
            if (c == CH_ESC)
            begin
                r.mode = M_ESC;
                r.done = 1'b0;
            end
        end
        else if (c < CH_LEAD)
        begin
            r.done = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ sv/ansi_escape_sequence_framer_top.sv @@
`timescale 1ns / 1ps
// Top level of the ECMA-48 escape sequence framer.
// Depends on aesf_pkg for mode codes, character constants and sizes.

// The framer takes one terminal byte per transaction and returns exactly one
// result per byte, in the cycle after acceptance, at a sustained rate of one byte
// per clock. The rate is set by the single next-state step on the parse mode
// and byte count registers, which each byte passes once. A result register on
// the output side lets a new byte be accepted in the same cycle as the pending
// result is taken; while the result is stalled the input is held off. Each
// result echoes the byte with its position in the current sequence, a restart
// flag (tuser), a last flag (tlast) and, on the last byte, the sequence length.
module ansi_escape_sequence_framer_top #(
    parameter int COUNT_BITS = aesf_pkg::COUNT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [aesf_pkg::IN_DATA_W-1:0]  s_tdata,   // [7:0] in_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [aesf_pkg::OUT_DATA_W-1:0] m_tdata,   // [7:0] out_byte,
                                                       // [23:8] position,
                                                       // [39:24] seq_len
    output logic                            m_tlast,   // last
    output logic                            m_tuser    // restarted
);
    import aesf_pkg::*;

    localparam int CW = (COUNT_BITS > FIELD_W) ? COUNT_BITS : FIELD_W + 1;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [2:0]            mode_reg, mode_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  sec_esc_reg, sec_esc_next;

    logic                  out_valid_reg;
    logic [7:0]            out_byte_reg;
    logic [FIELD_W-1:0]    out_pos_reg, pos_sat;
    logic [FIELD_W-1:0]    out_len_reg, len_val;
    logic                  out_restart_reg, out_last_reg;

    logic                  accept;
    logic [7:0]            c;
    logic [COUNT_BITS-1:0] cnt, cnt_inc, pos;
    logic                  done, restart, mash;
    logic [2:0]            mode_sw;
    first_res_t            first_res;
    logic [CW-1:0]         pos_ext, cnt_ext;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign c        = s_tdata;

    assign cnt_inc = (count_reg < CNT_MAX) ? count_reg + COUNT_BITS'(1) : count_reg;

    always_comb
    begin
        mode_sw      = mode_reg;
        done         = 1'b0;
        restart      = 1'b0;
        mash         = 1'b0;
        sec_esc_next = sec_esc_reg;
        first_res    = ascii_byte(c);
        if (cnt_inc == COUNT_BITS'(2))
        begin
            sec_esc_next = (c == CH_ESC);
        end

        case (mode_reg)
            M_ESC:
            begin
                if (c inside {[8'h20:8'h2F]})
                begin
                    if (c == CH_SP || c == CH_HASH)
                        mode_sw = M_NF;
                    else
                        done = 1'b1;
                end
                else if (c inside {[8'h30:8'h3F]})
                begin
                    done = 1'b1;
                end
                else if (c inside {[8'h40:8'h5F]})
                begin
                    if (c == CH_CSI)
                        mode_sw = M_CSI1;
                    else if (c inside {CH_SS2, CH_SS3})
                        mode_sw = M_SS;
                    else if (c inside {CH_DCS, CH_SOS, CH_OSC, CH_PM, CH_APC})
                        mode_sw = M_STR;
                    else
                        done = 1'b1;
                end
                else if (c == CH_ESC)
                begin
                    // a third or later ESC mashes the sequence down to one byte
                    if (cnt_inc < COUNT_BITS'(3))
                    begin
                        mode_sw = M_ESC;
                    end
                    else
                    begin
                        done = 1'b1;
                        mash = 1'b1;
                    end
                end
                else
                begin
                    done = 1'b1;
                end
            end
            M_SS:
            begin
                done = 1'b1;
            end
            M_NF:
            begin
                if (c inside {[8'h30:8'h7E]})
                    done = 1'b1;
                else if (!(c inside {[8'h20:8'h2F]}))
                    restart = 1'b1;
            end
            M_CSI1:
            begin
                if (c inside {[8'h20:8'h2F]})
                    mode_sw = M_CSI2;
                else if (c == CH_CSI && (cnt_inc == COUNT_BITS'(3)
                         || (cnt_inc == COUNT_BITS'(4) && sec_esc_next)))
                    mode_sw = M_CSI1;   // linux function key: hold parameter mode
                else if (c inside {[8'h40:8'h7E]})
                    done = 1'b1;
                else if (!(c inside {[8'h30:8'h3F]}))
                    restart = 1'b1;
            end
            M_CSI2:
            begin
                if (c inside {[8'h40:8'h7E]})
                    done = 1'b1;
                else if (!(c inside {[8'h20:8'h2F]}))
                    restart = 1'b1;
            end
            M_STR:
            begin
                if (c == CH_BEL)
                    done = 1'b1;
                else if (c == CH_ESC || c == CH_C2)
                    mode_sw = M_STR2;
            end
            M_STR2:
            begin
                if (c inside {CH_BEL, CH_BSL, CH_C1ST})
                    done = 1'b1;
                else
                    mode_sw = M_STR;
            end
            default:
            begin
                done    = first_res.done;
                mode_sw = first_res.mode;
            end
        endcase

        cnt = cnt_inc;
        pos = count_reg;
        // drop earlier bytes and treat this one as the first of a new sequence
        if (restart)
        begin
            cnt     = COUNT_BITS'(1);
            pos     = '0;
            done    = first_res.done;
            mode_sw = first_res.mode;
        end

        if (done)
        begin
            mode_next  = M_ASCII;
            count_next = '0;
        end
        else
        begin
            mode_next  = mode_sw;
            count_next = cnt;
        end
    end

    assign pos_ext = CW'(pos);
    assign cnt_ext = CW'(cnt);
    assign pos_sat = (pos_ext > CW'({FIELD_W{1'b1}})) ? {FIELD_W{1'b1}} : pos_ext[FIELD_W-1:0];
    assign len_val = !done ? '0 :
                     mash  ? FIELD_W'(1) :
                     (cnt_ext > CW'({FIELD_W{1'b1}})) ? {FIELD_W{1'b1}} : cnt_ext[FIELD_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= M_ASCII;
            count_reg     <= '0;
            sec_esc_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg    <= mode_next;
                count_reg   <= count_next;
                sec_esc_reg <= sec_esc_next;
            end
            if (s_tready)
            begin
                out_valid_reg <= s_tvalid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_byte_reg    <= c;
            out_pos_reg     <= pos_sat;
            out_restart_reg <= restart;
            out_last_reg    <= done;
            out_len_reg     <= len_val;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_pos_reg, out_byte_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_restart_reg;

    a_len_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (out_len_reg == '0))
        else $error("sequence length reported on a byte that is not last");

    a_restart_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (out_pos_reg == '0))
        else $error("restarted byte not at position zero");

    a_last_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done) |=> (count_reg == '0 && mode_reg == M_ASCII))
        else $error("state not cleared after a completed sequence");

    a_result_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted byte produced no result");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

endmodule

@@ sim/tb_ansi_escape_sequence_framer_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the ECMA-48 escape sequence framer top level.
// Needs aesf_pkg and ansi_escape_sequence_framer_top; predicts every result in-line.
module tb_ansi_escape_sequence_framer_top;

    import aesf_pkg::*;

    localparam int unsigned CNT_MAX = (1 << COUNT_BITS_DEF) - 1;

    typedef struct packed {
        logic [7:0]  data;
        logic [15:0] pos;
        logic        restarted;
        logic        is_last;
        logic [15:0] len;
    } framer_res_t;

    logic                  clk;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;

    // Byte stream still to be offered, and results still owed by the block
    logic [7:0]  byte_q [$];
    framer_res_t frame_q [$];

    int unsigned pushed     = 0;
    int unsigned in_count   = 0;
    int unsigned fail_count = 0;
    logic        in_taken   = 1'b0;

    int unsigned src_idle_pct = 0;
    int unsigned snk_idle_pct = 0;
    logic        hold_req     = 1'b0;
    int unsigned hold_left    = 0;
    logic        hold_done    = 1'b0;

    // Tokeniser state mirrored by the predictor
    logic [2:0]  mode_r    = M_ASCII;
    int unsigned count_r   = 0;
    logic        sec_esc_r = 1'b0;

    ansi_escape_sequence_framer_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic [15:0] clamp16(input int unsigned v);
        return (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    // First byte of a sequence: ESC opens escape mode, a continuation byte waits
    function automatic logic lead_byte_ends(input logic [7:0] c);
        if (c == CH_ESC)
        begin
            mode_r = M_ESC;
            return 1'b0;
        end
        mode_r = M_ASCII;
        return (c < CH_CONT) || (c >= CH_LEAD);
    endfunction

    function automatic framer_res_t frame_byte(input logic [7:0] c);
        int unsigned pos;
        int unsigned cnt;
        logic        done;
        logic        restart;
        logic        mash;
        framer_res_t r;
        pos     = count_r;
        cnt     = count_r;
        done    = 1'b0;
        restart = 1'b0;
        mash    = 1'b0;
        if (cnt < CNT_MAX)
            cnt++;
        if (cnt == 2)
            sec_esc_r = (c == CH_ESC);
        case (mode_r)
            M_ESC:
            begin
                if (c >= 8'h20 && c <= 8'h2F)
                begin
                    if (c == CH_SP || c == CH_HASH)
                        mode_r = M_NF;
                    else
                        done = 1'b1;
                end
                else if (c >= 8'h40 && c <= 8'h5F)
                begin
                    if (c == CH_CSI)
                        mode_r = M_CSI1;
                    else if (c == CH_SS2 || c == CH_SS3)
                        mode_r = M_SS;
                    else if (c == CH_DCS || c == CH_SOS || c == CH_OSC || c == CH_PM
                             || c == CH_APC)
                        mode_r = M_STR;
                    else
                        done = 1'b1;
                end
                else if (c == CH_ESC)
                begin
                    // ESC ESC is alt chording; a third ESC mashes the sequence
                    if (cnt >= 3)
                    begin
                        done = 1'b1;
                        mash = 1'b1;
                    end
                end
                else
                    done = 1'b1;
            end
            M_SS:
                done = 1'b1;
            M_NF:
            begin
                if (c >= 8'h30 && c <= 8'h7E)
                    done = 1'b1;
                else if (!(c >= 8'h20 && c <= 8'h2F))
                    restart = 1'b1;
            end
            M_CSI1:
            begin
                if (c >= 8'h20 && c <= 8'h2F)
                    mode_r = M_CSI2;
                else if (c == CH_CSI && (cnt == 3 || (cnt == 4 && sec_esc_r)))
                    mode_r = M_CSI1;
                else if (c >= 8'h40 && c <= 8'h7E)
                    done = 1'b1;
                else if (!(c >= 8'h30 && c <= 8'h3F))
                    restart = 1'b1;
            end
            M_CSI2:
            begin
                if (c >= 8'h40 && c <= 8'h7E)
                    done = 1'b1;
                else if (!(c >= 8'h20 && c <= 8'h2F))
                    restart = 1'b1;
            end
            M_STR:
            begin
                if (c == CH_BEL)
                    done = 1'b1;
                else if (c == CH_ESC || c == CH_C2)
                    mode_r = M_STR2;
            end
            M_STR2:
            begin
                if (c == CH_BEL || c == CH_BSL || c == CH_C1ST)
                    done = 1'b1;
                else
                    mode_r = M_STR;
            end
            default:
                done = lead_byte_ends(c);
        endcase
        if (restart)
        begin
            cnt  = 1;
            pos  = 0;
            done = lead_byte_ends(c);
        end
        r.data      = c;
        r.pos       = clamp16(pos);
        r.restarted = restart;
        r.is_last   = done;
        r.len       = done ? (mash ? 16'd1 : clamp16(cnt)) : 16'd0;
        if (done)
        begin
            mode_r  = M_ASCII;
            count_r = 0;
        end
        else
            count_r = cnt;
        return r;
    endfunction

    // Sender: hold the current byte until taken, then offer the next or idle
    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || in_taken))
        begin
            if (byte_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_q.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Receiver: random back-pressure plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end
        else if (hold_req && !hold_done)
        begin
            hold_left = 300;
            hold_done = 1'b1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Check results first: each one belongs to a byte taken at an earlier edge
    always @(posedge clk)
    begin
        framer_res_t got;
        framer_res_t want;
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                got.data      = m_tdata[7:0];
                got.pos       = m_tdata[23:8];
                got.len       = m_tdata[39:24];
                got.is_last   = m_tlast;
                got.restarted = m_tuser;
                if (frame_q.size() == 0)
                begin
                    fail_count++;
                    $display({"%0t: unexpected result, expected none, got byte %h ",
                              "pos %0d restart %b last %b len %0d"},
                             $time, got.data, got.pos, got.restarted, got.is_last,
                             got.len);
                end
                else
                begin
                    want = frame_q.pop_front();
                    if (got.data != want.data || got.pos != want.pos
                        || got.restarted != want.restarted || got.is_last != want.is_last
                        || got.len != want.len)
                    begin
                        fail_count++;
                        $display({"%0t: mismatch, expected byte %h pos %0d restart %b ",
                                  "last %b len %0d, got byte %h pos %0d restart %b ",
                                  "last %b len %0d"},
                                 $time, want.data, want.pos, want.restarted,
                                 want.is_last, want.len, got.data, got.pos,
                                 got.restarted, got.is_last, got.len);
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                frame_q.push_back(frame_byte(s_tdata));
                in_count++;
                in_taken = 1'b1;
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        byte_q.push_back(b);
        pushed++;
    endtask

    task automatic push_range(input int n, input logic [7:0] lo, input logic [7:0] hi);
        repeat (n)
            push_byte(8'($urandom_range(hi, lo)));
    endtask

    // One token: mostly well-formed sequences with random content, some noise
    task automatic push_token();
        int          k;
        logic [7:0]  b;
        logic [7:0]  str_open [5];
        k = $urandom_range(99);
        str_open = '{CH_DCS, CH_SOS, CH_OSC, CH_PM, CH_APC};
        if (k < 12)
        begin
            b = 8'($urandom_range(8'h7F));
            push_byte((b == CH_ESC) ? 8'h41 : b);
        end
        else if (k < 20)
        begin
            push_range($urandom_range(3), 8'h80, 8'hBF);
            push_range(1, 8'hC0, 8'hFF);
        end
        else if (k < 40)
        begin
            push_byte(CH_ESC);
            // alt chord prefix
            if ($urandom_range(4) == 0)
                push_byte(CH_ESC);
            push_byte(CH_CSI);
            if ($urandom_range(5) == 0)
                push_byte(CH_CSI);
            push_range($urandom_range(4), 8'h30, 8'h3F);
            push_range($urandom_range(2), 8'h20, 8'h2F);
            push_range(1, 8'h40, 8'h7E);
        end
        else if (k < 48)
        begin
            push_byte(CH_ESC);
            push_byte($urandom_range(1) ? CH_SS3 : CH_SS2);
            push_range(1, 8'h00, 8'hFF);
        end
        else if (k < 56)
        begin
            push_byte(CH_ESC);
            push_byte($urandom_range(1) ? CH_HASH : CH_SP);
            push_range($urandom_range(2), 8'h20, 8'h2F);
            push_range(1, 8'h30, 8'h7E);
        end
        else if (k < 66)
        begin
            push_byte(CH_ESC);
            b = 8'($urandom_range(8'h7F, 8'h21));
            if (b == CH_CSI || b == CH_SS2 || b == CH_SS3 || b == CH_HASH || b == CH_ESC
                || b == CH_DCS || b == CH_SOS || b == CH_OSC || b == CH_PM || b == CH_APC)
                b = 8'h63;
            push_byte(b);
        end
        else if (k < 76)
        begin
            push_byte(CH_ESC);
            push_byte(str_open[$urandom_range(4)]);
            repeat ($urandom_range(8))
            begin
                // arm the terminator, then fall back to string mode
                if ($urandom_range(7) == 0)
                begin
                    push_byte($urandom_range(1) ? CH_ESC : CH_C2);
                    push_range(1, 8'h20, 8'h5B);
                end
                else
                    push_range(1, 8'h20, 8'h7E);
            end
            case ($urandom_range(3))
                0: push_byte(CH_BEL);
                1:
                begin
                    push_byte(CH_ESC);
                    push_byte(CH_BSL);
                end
                2:
                begin
                    push_byte(CH_C2);
                    push_byte(CH_C1ST);
                end
                default:
                begin
                    push_byte($urandom_range(1) ? CH_ESC : CH_C2);
                    push_byte(CH_BEL);
                end
            endcase
        end
        else if (k < 82)
            repeat ($urandom_range(5, 3))
                push_byte(CH_ESC);
        else if (k < 90)
        begin
            push_byte(CH_ESC);
            case ($urandom_range(2))
                0: push_byte(CH_SP);
                1: push_byte(CH_CSI);
                default:
                begin
                    push_byte(CH_CSI);
                    push_range(1, 8'h20, 8'h2F);
                end
            endcase
            push_range($urandom_range(1), 8'h30, 8'h3F);
            if ($urandom_range(1))
                push_range(1, 8'h00, 8'h1F);
            else
                push_range(1, 8'h80, 8'hFF);
        end
        else
            push_range($urandom_range(4, 1), 8'h00, 8'hFF);
    endtask

    task automatic wait_drain();
        do
            @(negedge clk);
        while (in_count != pushed || frame_q.size() != 0);
    endtask

    initial
    begin
        logic [7:0] opening [24];
        opening = '{8'h00, 8'hFF, CH_CONT, 8'h7F,
                    CH_ESC, CH_CSI, 8'h31, 8'h3B, 8'h41,
                    CH_ESC, CH_SP, 8'h01,
                    CH_ESC, CH_ESC, CH_ESC,
                    CH_ESC, CH_CSI, CH_CSI, 8'h41,
                    CH_ESC, CH_OSC, 8'h41, CH_C2, CH_C1ST};
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        src_idle_pct <= 30;
        snk_idle_pct <= 62;
        @(posedge clk);
        foreach (opening[i])
            push_byte(opening[i]);
        while (pushed < 470)
            push_token();
        wait_drain();

        // Long receiver hold-off while the sender keeps offering
        src_idle_pct <= 62;
        snk_idle_pct <= 30;
        @(posedge clk);
        hold_req <= 1'b1;
        while (pushed < 940)
            push_token();
        wait_drain();

        repeat ($urandom_range(20, 5))
            @(posedge clk);
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        @(posedge clk);
        while (pushed < 1400)
            push_token();
        wait_drain();

        repeat (8)
            @(negedge clk);
        if (fail_count == 0 && frame_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #4ms;
        $display("%0t: timeout, %0d bytes taken of %0d", $time, in_count, pushed);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
